### rtl/core/slud_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted list union unit: word types for both channels,
// command codes, and the command/status groups between controller and datapath.
// No dependencies.
package slud_pkg;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_RUN    = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic               last;
		logic               empty_res;
		logic [5:0]         total;
		logic               overflow;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic start;
		logic skip;
		logic emit;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip_any;
		logic at_end;
		logic out_free;
		logic pend_valid;
	} dp_stat_t;

endpackage

### rtl/core/slud_dp.sv
`timescale 1ns / 1ps
// Datapath of the sorted list union unit: both list memories, fill counts,
// walk pointers, head compare, one-word pending stage and the output register.
// Depends on slud_pkg.
module slud_dp #(
	parameter int LIST_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slud_pkg::dp_cmd_t  cmd,
	input  logic signed [31:0] load_value,
	output slud_pkg::dp_stat_t stat,
	output logic               res_valid,
	input  logic               res_stall,
	output slud_pkg::res_t     res
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic signed [31:0] mem_a [LIST_DEPTH];
	logic signed [31:0] mem_b [LIST_DEPTH];
	logic signed [31:0] rd_a_q, rd_b_q;
	logic signed [31:0] last_a_q, last_b_q;
	logic signed [31:0] pend_q;
	logic [CW-1:0]      count_a_q, count_b_q;
	logic [CW-1:0]      ptr_a_q, ptr_b_q;
	logic               skip_a_q, skip_b_q;
	logic               drop_q;
	logic               pend_valid_q;
	logic [5:0]         k_q;
	logic               res_valid_q;
	slud_pkg::res_t     res_q;

	logic               full_a, full_b;
	logic               a_ok, b_ok, a_rep, b_rep;
	logic               take_a, take_b;
	logic signed [31:0] sel_val;
	logic               push_pend;

	assign full_a = (count_a_q == DEPTH_C);
	assign full_b = (count_b_q == DEPTH_C);

	// list memories: one write port (append), one registered read at the pointer
	always_ff @(posedge clk) begin
		if (cmd.load_a && !full_a)
			mem_a[count_a_q[AW-1:0]] <= load_value;
		rd_a_q <= mem_a[ptr_a_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_b && !full_b)
			mem_b[count_b_q[AW-1:0]] <= load_value;
		rd_b_q <= mem_b[ptr_b_q[AW-1:0]];
	end

	assign a_ok  = (ptr_a_q < count_a_q);
	assign b_ok  = (ptr_b_q < count_b_q);
	// head still equal to the word just taken from that list: drop it
	assign a_rep = skip_a_q && a_ok && (rd_a_q == last_a_q);
	assign b_rep = skip_b_q && b_ok && (rd_b_q == last_b_q);

	always_comb begin
		take_a = 1'b0;
		take_b = 1'b0;
		if (a_ok && b_ok) begin
			if (rd_a_q == rd_b_q) begin
				take_a = 1'b1;
				take_b = 1'b1;
			end else if (rd_b_q < rd_a_q) begin
				take_b = 1'b1;
			end else begin
				take_a = 1'b1;
			end
		end else if (a_ok) begin
			take_a = 1'b1;
		end else begin
			take_b = b_ok;
		end
		sel_val = take_a ? rd_a_q : rd_b_q;
	end

	assign push_pend = cmd.emit && pend_valid_q;

	assign stat.skip_any   = a_rep || b_rep;
	assign stat.at_end     = !a_ok && !b_ok;
	assign stat.out_free   = !res_valid_q || !res_stall;
	assign stat.pend_valid = pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q    <= '0;
			count_b_q    <= '0;
			ptr_a_q      <= '0;
			ptr_b_q      <= '0;
			skip_a_q     <= 1'b0;
			skip_b_q     <= 1'b0;
			drop_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			k_q          <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;

			if (cmd.load_a) begin
				if (full_a)
					drop_q <= 1'b1;
				else
					count_a_q <= count_a_q + ONE_C;
			end
			if (cmd.load_b) begin
				if (full_b)
					drop_q <= 1'b1;
				else
					count_b_q <= count_b_q + ONE_C;
			end

			if (cmd.start) begin
				ptr_a_q      <= '0;
				ptr_b_q      <= '0;
				skip_a_q     <= 1'b0;
				skip_b_q     <= 1'b0;
				pend_valid_q <= 1'b0;
				k_q          <= '0;
			end

			if (cmd.skip) begin
				if (a_rep)
					ptr_a_q <= ptr_a_q + ONE_C;
				else
					skip_a_q <= 1'b0;
				if (b_rep)
					ptr_b_q <= ptr_b_q + ONE_C;
				else
					skip_b_q <= 1'b0;
			end

			if (cmd.emit) begin
				skip_a_q     <= take_a;
				skip_b_q     <= take_b;
				if (take_a)
					ptr_a_q <= ptr_a_q + ONE_C;
				if (take_b)
					ptr_b_q <= ptr_b_q + ONE_C;
				pend_valid_q <= 1'b1;
				k_q          <= k_q + 6'd1;
				if (pend_valid_q)
					res_valid_q <= 1'b1;
			end

			if (cmd.finish) begin
				res_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
				count_a_q    <= '0;
				count_b_q    <= '0;
				drop_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (take_a)
				last_a_q <= rd_a_q;
			if (take_b)
				last_b_q <= rd_b_q;
			pend_q <= sel_val;
		end
		if (push_pend) begin
			res_q.out_value <= pend_q;
			res_q.last      <= 1'b0;
			res_q.empty_res <= 1'b0;
			res_q.total     <= '0;
			res_q.overflow  <= drop_q;
		end else if (cmd.finish) begin
			res_q.out_value <= pend_valid_q ? pend_q : '0;
			res_q.last      <= 1'b1;
			res_q.empty_res <= !pend_valid_q;
			res_q.total     <= pend_valid_q ? k_q : 6'd0;
			res_q.overflow  <= drop_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/core/slud_ctrl.sv
`timescale 1ns / 1ps
// Controller of the sorted list union unit: accepts input words, sequences
// the read/step loop of a run and issues datapath commands.
// Depends on slud_pkg.
module slud_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         item_cmd,
	input  slud_pkg::dp_stat_t stat,
	output slud_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_STEP = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (item_cmd)
						slud_pkg::CMD_LOAD_A: cmd.load_a = 1'b1;
						slud_pkg::CMD_LOAD_B: cmd.load_b = 1'b1;
						slud_pkg::CMD_RUN: begin
							cmd.start = 1'b1;
							state_d   = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (stat.skip_any) begin
					cmd.skip = 1'b1;
					state_d  = ST_READ;
				end else if (stat.at_end) begin
					// hold until the output register can take the final word
					if (stat.out_free) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end else if (!stat.pend_valid || stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### rtl/core/sorted_list_union_dedup_unit.sv
`timescale 1ns / 1ps
// Top level of the sorted list union unit: controller plus datapath.
// Depends on slud_pkg, slud_ctrl and slud_dp.
//
//   channel | handshake              | word
//   --------+------------------------+----------------------------------
//   item    | item_valid, item_stall | slud_pkg::item_t (cmd, value)
//   res     | res_valid, res_stall   | slud_pkg::res_t (out_value, last,
//           |                        |   empty_res, total, overflow)
//
// A run walks both lists through a registered read of each list memory: each
// distinct result word and each skip step (one step drops the next repeated
// element of one list or of both) passes through a read state and then a step
// state, and so does the close of the run. Input is stalled for the whole run.
// Reset clears counts, overflow flag and control; list contents stay undefined.
// A stalled output holds the walk once a second result word is ready.
module sorted_list_union_dedup_unit #(
	parameter int LIST_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  slud_pkg::item_t item,
	output logic            res_valid,
	input  logic            res_stall,
	output slud_pkg::res_t  res
);

	slud_pkg::dp_cmd_t  dp_cmd;
	slud_pkg::dp_stat_t dp_stat;

	slud_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_cmd   (item.cmd),
		.stat       (dp_stat),
		.cmd        (dp_cmd)
	);

	slud_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.load_value (item.value),
		.stat       (dp_stat),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_list_union_dedup_unit: loads sorted, repeated and unsorted
// lists, runs merges under random idling and checks every result word in order.
// Depends on slud_pkg and the RTL of the unit.
module tb;
	import slud_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int ITEM_GOAL = 260;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	typedef int int_q_t[$];

	class union_scoreboard;
		logic signed [31:0] store [2][LIST_DEPTH];
		int fill [2];
		bit dropped;
		res_t union_words [$];
		int errors;

		task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
			if (errors < 40)
				$display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, field, got,
					want);
			errors++;
		endtask

		function int pending();
			return union_words.size();
		endfunction

		// skip entries equal to their predecessor in the same list
		function int next_distinct(int side, int pos);
			while (pos < fill[side] && store[side][pos] == store[side][pos - 1])
				pos++;
			return pos;
		endfunction

		function void merge_lists();
			res_t held;
			int pa, pb, n;
			logic signed [31:0] x, y, pick;
			pa = 0;
			pb = 0;
			n = 0;
			held = '0;
			held.overflow = dropped;
			if (fill[0] == 0 && fill[1] == 0) begin
				held.last = 1'b1;
				held.empty_res = 1'b1;
				union_words.push_back(held);
			end else begin
				while (pa < fill[0] || pb < fill[1]) begin
					if (pa < fill[0] && pb < fill[1]) begin
						x = store[0][pa];
						y = store[1][pb];
						if (x == y) begin
							pick = x;
							pa = next_distinct(0, pa + 1);
							pb = next_distinct(1, pb + 1);
						end else if (y < x) begin
							pick = y;
							pb = next_distinct(1, pb + 1);
						end else begin
							pick = x;
							pa = next_distinct(0, pa + 1);
						end
					end else if (pb < fill[1]) begin
						pick = store[1][pb];
						pb = next_distinct(1, pb + 1);
					end else begin
						pick = store[0][pa];
						pa = next_distinct(0, pa + 1);
					end
					// hold one word back so the final one can be marked
					if (n > 0)
						union_words.push_back(held);
					held.out_value = pick;
					n++;
				end
				held.last = 1'b1;
				held.total = n[5:0];
				union_words.push_back(held);
			end
			fill[0] = 0;
			fill[1] = 0;
			dropped = 1'b0;
		endfunction

		function void note_item(item_t w);
			int side;
			case (w.cmd)
				CMD_LOAD_A, CMD_LOAD_B: begin
					side = (w.cmd == CMD_LOAD_B) ? 1 : 0;
					if (fill[side] < LIST_DEPTH) begin
						store[side][fill[side]] = w.value;
						fill[side]++;
					end else begin
						dropped = 1'b1;
					end
				end
				CMD_RUN: merge_lists();
				default: ;
			endcase
		endfunction

		task check_result(res_t got);
			res_t want;
			if (union_words.size() == 0) begin
				report_mismatch("unexpected word", got.out_value, '0);
				return;
			end
			want = union_words.pop_front();
			if (got.out_value !== want.out_value)
				report_mismatch("out_value", got.out_value, want.out_value);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
			if (got.empty_res !== want.empty_res)
				report_mismatch("empty_res", got.empty_res, want.empty_res);
			if (got.total !== want.total)
				report_mismatch("total", got.total, want.total);
			if (got.overflow !== want.overflow)
				report_mismatch("overflow", got.overflow, want.overflow);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	union_scoreboard sb = new;
	int words_sent = 0;
	int send_idle_pct = 16;
	int recv_idle_pct = 45;
	int quiet = 0;

	sorted_list_union_dedup_unit #(
		.LIST_DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_word(input logic [1:0] c, input logic signed [31:0] v);
		item_t w;
		w.cmd = c;
		w.value = v;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(w);
		words_sent++;
	endtask

	// hold the input off until every expected word is out
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic set_phase(input int sender_pct, input int receiver_pct);
		drain_results();
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	function automatic int_q_t ascending_run(int count, longint start, int unsigned step);
		int_q_t q;
		longint cur;
		cur = start;
		for (int k = 0; k < count; k++) begin
			if (cur > longint'(INT_MAX))
				cur = longint'(INT_MAX);
			q.push_back(int'(cur));
			cur += $urandom_range(step, 0);
		end
		return q;
	endfunction

	task automatic load_and_run(input int_q_t qa, input int_q_t qb);
		int ia, ib;
		ia = 0;
		ib = 0;
		while (ia < qa.size() || ib < qb.size()) begin
			if ($urandom_range(19) == 0)
				send_word(CMD_UNUSED, $urandom);
			if (ib >= qb.size() || (ia < qa.size() && $urandom_range(1) == 0)) begin
				send_word(CMD_LOAD_A, qa[ia]);
				ia++;
			end else begin
				send_word(CMD_LOAD_B, qb[ib]);
				ib++;
			end
		end
		send_word(CMD_RUN, $urandom);
	endtask

	task automatic send_sorted_pair();
		int na, nb;
		longint base;
		na = ($urandom_range(9) == 0) ? $urandom_range(LIST_DEPTH) : $urandom_range(6);
		nb = ($urandom_range(9) == 0) ? $urandom_range(LIST_DEPTH) : $urandom_range(6);
		if ($urandom_range(1) == 0) begin
			// narrow window: plenty of repeats and shared values
			case ($urandom_range(3))
				0: base = longint'(INT_MIN);
				1: base = -4;
				2: base = longint'(INT_MAX) - 30;
				default: base = longint'($signed($urandom));
			endcase
			load_and_run(ascending_run(na, base + $urandom_range(3), 3),
				ascending_run(nb, base + $urandom_range(3), 3));
		end else begin
			load_and_run(ascending_run(na, longint'($signed($urandom)), 1 << 26),
				ascending_run(nb, longint'($signed($urandom)), 1 << 26));
		end
	endtask

	// one or both lists loaded past their depth
	task automatic send_overflow(input bit widest);
		int_q_t qa, qb;
		int base;
		longint start;
		if (widest) begin
			// interleaved distinct values give the longest possible run
			base = int'($urandom_range(32'h3fff_ffff)) - 32'sh2000_0000;
			for (int k = 0; k < LIST_DEPTH; k++) begin
				qa.push_back(base + 2 * k);
				qb.push_back(base + 2 * k + 1);
			end
			qa.push_back($urandom);
			qb.push_back($urandom);
		end else begin
			start = longint'($signed($urandom)) >>> 1;
			qa = ascending_run(LIST_DEPTH + $urandom_range(1, 3), start, 1 << 20);
			qb = ascending_run($urandom_range(4), start, 1 << 20);
			if ($urandom_range(1) == 0) begin
				qb = qa;
				qa = ascending_run($urandom_range(4), start, 1 << 20);
			end
		end
		load_and_run(qa, qb);
	endtask

	task automatic send_noise();
		int n;
		logic [1:0] c;
		n = $urandom_range(8);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(4))
				0, 1: c = CMD_LOAD_A;
				2, 3: c = CMD_LOAD_B;
				default: c = CMD_UNUSED;
			endcase
			send_word(c, $urandom);
		end
		send_word(CMD_RUN, $urandom);
	endtask

	initial begin
		int kind;
		int phase;
		phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both lists empty
		send_word(CMD_RUN, 32'sd0);
		// extremes, one value shared by both lists
		send_word(CMD_LOAD_A, INT_MIN);
		send_word(CMD_LOAD_A, -32'sd1);
		send_word(CMD_LOAD_A, 32'sd0);
		send_word(CMD_LOAD_B, 32'sd0);
		send_word(CMD_LOAD_B, INT_MAX);
		send_word(CMD_RUN, -32'sd1);
		// repeats in list A only, list B empty
		send_word(CMD_LOAD_A, 32'sd5);
		send_word(CMD_LOAD_A, 32'sd5);
		send_word(CMD_LOAD_A, 32'sd5);
		send_word(CMD_RUN, INT_MAX);
		// list A empty, unused command in between
		send_word(CMD_LOAD_B, -32'sd7);
		send_word(CMD_UNUSED, 32'sd123);
		send_word(CMD_LOAD_B, 32'sd3);
		send_word(CMD_LOAD_B, 32'sd3);
		send_word(CMD_RUN, INT_MIN);
		// lists out of order
		send_word(CMD_LOAD_A, 32'sd9);
		send_word(CMD_LOAD_A, 32'sd2);
		send_word(CMD_LOAD_B, 32'sd4);
		send_word(CMD_LOAD_B, 32'sd4);
		send_word(CMD_LOAD_B, 32'sd1);
		send_word(CMD_RUN, 32'sd0);

		send_overflow(1'b1);
		while (words_sent < ITEM_GOAL) begin
			if (phase == 0 && words_sent >= 120) begin
				set_phase(45, 16);
				phase = 1;
			end else if (phase == 1 && words_sent >= 190) begin
				set_phase(0, 0);
				phase = 2;
			end
			kind = $urandom_range(99);
			if (kind < 75)
				send_sorted_pair();
			else if (kind < 88)
				send_noise();
			else if (kind < 94)
				send_overflow(1'b0);
			else
				send_word(CMD_RUN, $urandom);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sorted_list_union_dedup_unit.f
rtl/core/slud_pkg.sv
rtl/core/slud_dp.sv
rtl/core/slud_ctrl.sv
rtl/core/sorted_list_union_dedup_unit.sv
tb/tb.sv
